// ===== rtl/core/rpc_pkg.sv =====
package rpc_pkg;

   // Field formats
   localparam int COORD_WIDTH       = 16;
   localparam int FIRST_WIDTH       = 17;
   localparam int SECOND_WIDTH      = 16;
   localparam int ANGLE_WIDTH       = 16;

   // CORDIC sizing
   localparam int CORDIC_ITERATIONS = 16;
   localparam int TABLE_LEN         = 24;
   localparam int N_ITER            = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN
                                                                      : CORDIC_ITERATIONS;
   localparam int IDX_WIDTH         = $clog2(TABLE_LEN);
   localparam int GUARD_BITS        = 4;
   // datapath: coordinate + guard bits + room for gain and pre-rotation growth
   localparam int XW                = COORD_WIDTH + GUARD_BITS + 3;
   // angle accumulator in 2^-16 degree units, covers +/-180 plus slack
   localparam int ZW                = 26;
   // compare width for input clamping
   localparam int CW2               = ((COORD_WIDTH > FIRST_WIDTH) ? COORD_WIDTH
                                                                  : FIRST_WIDTH) + 1;

   // Gain compensation
   localparam int KW                = 25;
   localparam int PW                = XW + KW;
   localparam int GAIN_SHIFT        = 24;
   localparam int DSHIFT            = GAIN_SHIFT + GUARD_BITS;
   localparam logic signed [KW-1:0] GAIN_K = KW'(10188014);
   localparam logic signed [PW-1:0] ROUND_BIAS = PW'(64'sd1 <<< (DSHIFT - 1));

   // Angle constants
   localparam logic signed [ZW-1:0] DEG90 = ZW'(5898240);
   localparam int HALF_TURN          = 23040;
   localparam int FULL_TURN          = 46080;
   localparam int Z_ROUND            = 256;
   localparam int Z_SHIFT            = 9;

   // Coordinate and magnitude limits
   localparam longint CMAX_L = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam longint CMIN_L = -(64'sd1 <<< (COORD_WIDTH - 1));
   localparam longint MMAX_L = (64'sd1 <<< COORD_WIDTH) - 64'sd1;

   // Mode codes
   localparam logic KIND_RECT  = 1'b0;
   localparam logic KIND_POLAR = 1'b1;

   // Data carried through the CORDIC stages
   typedef struct packed {
      logic                          polar;
      logic                          zero_vec;
      logic                          neg_axis;
      logic signed [XW-1:0]          x;
      logic signed [XW-1:0]          y;
      logic signed [ZW-1:0]          z;
      logic signed [COORD_WIDTH-1:0] x_echo;
      logic signed [COORD_WIDTH-1:0] y_echo;
      logic [COORD_WIDTH-1:0]        mag_echo;
      logic signed [ANGLE_WIDTH-1:0] ang_echo;
   } cordic_type;

   // After the gain multiply
   typedef struct packed {
      logic                          polar;
      logic                          zero_vec;
      logic                          neg_axis;
      logic signed [PW-1:0]          px;
      logic signed [PW-1:0]          py;
      logic signed [ANGLE_WIDTH-1:0] ang_cordic;
      logic signed [COORD_WIDTH-1:0] x_echo;
      logic signed [COORD_WIDTH-1:0] y_echo;
      logic [COORD_WIDTH-1:0]        mag_echo;
      logic signed [ANGLE_WIDTH-1:0] ang_echo;
   } prod_type;

   // One result
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_out;
      logic signed [COORD_WIDTH-1:0] y_out;
      logic [COORD_WIDTH-1:0]        magnitude;
      logic signed [ANGLE_WIDTH-1:0] angle;
      logic                          is_polar;
   } rsp_type;

   // atan(2^-i) in 2^-16 degree units; entry 0 is 45 degrees
   function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_WIDTH-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = ZW'(2949120);
         5'd1:  v = ZW'(1740967);
         5'd2:  v = ZW'(919879);
         5'd3:  v = ZW'(466945);
         5'd4:  v = ZW'(234379);
         5'd5:  v = ZW'(117304);
         5'd6:  v = ZW'(58666);
         5'd7:  v = ZW'(29335);
         5'd8:  v = ZW'(14668);
         5'd9:  v = ZW'(7334);
         5'd10: v = ZW'(3667);
         5'd11: v = ZW'(1833);
         5'd12: v = ZW'(917);
         5'd13: v = ZW'(458);
         5'd14: v = ZW'(229);
         5'd15: v = ZW'(115);
         5'd16: v = ZW'(57);
         5'd17: v = ZW'(29);
         5'd18: v = ZW'(14);
         5'd19: v = ZW'(7);
         5'd20: v = ZW'(4);
         5'd21: v = ZW'(2);
         5'd22: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/rect_polar_converter_top.sv =====
// Rectangular/polar vector converter. Each request carries a mode and two
// operands: in rectangular mode x and y (signed Q8.8) give back the saturated
// x and y, the length (unsigned Q8.8) and the four-quadrant angle (signed
// Q8.7 degrees, +/-180); in polar mode a length and an angle give back x and
// y, saturated to the coordinate range, plus the clamped length and wrapped
// angle. The datapath is a fixed-length CORDIC with one register stage per
// micro-rotation: one operand-prep stage, CORDIC_ITERATIONS rotation stages,
// one gain-multiply stage and one output stage; a result is presented once its
// request has passed through all of these registers,
// and can be taken at the next edge.
// A new request is taken every cycle; req_ready drops only while a result
// sits in the output skid register waiting for rsp_ready, and the whole
// pipeline then holds. There is no state and no configuration.
module rect_polar_converter_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_kind,
   input  logic signed [rpc_pkg::FIRST_WIDTH-1:0]  req_first_operand,
   input  logic signed [rpc_pkg::SECOND_WIDTH-1:0] req_second_operand,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [rpc_pkg::COORD_WIDTH-1:0]  rsp_x_out,
   output logic signed [rpc_pkg::COORD_WIDTH-1:0]  rsp_y_out,
   output logic [rpc_pkg::COORD_WIDTH-1:0]         rsp_magnitude,
   output logic signed [rpc_pkg::ANGLE_WIDTH-1:0]  rsp_angle,
   output logic                                    rsp_is_polar
);
   import rpc_pkg::*;

   logic       advance;
   logic       stage_valid [0:N_ITER];
   cordic_type stage_data  [0:N_ITER];
   rsp_type    rsp_data;

   assign req_ready = advance;

   // Operand prep
   rpc_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (req_valid),
      .kind           (req_kind),
      .first_operand  (req_first_operand),
      .second_operand (req_second_operand),
      .out_valid      (stage_valid[0]),
      .out_data       (stage_data[0])
   );

   // CORDIC micro-rotation stages
   for (genvar gi = 0; gi < N_ITER; gi++) begin : g_iter
      rpc_iter u_iter (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .idx       (IDX_WIDTH'(gi)),
         .in_valid  (stage_valid[gi]),
         .in_data   (stage_data[gi]),
         .out_valid (stage_valid[gi+1]),
         .out_data  (stage_data[gi+1])
      );
   end

   // Gain compensation, saturation and output
   rpc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[N_ITER]),
      .in_data   (stage_data[N_ITER]),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_x_out     = rsp_data.x_out;
   assign rsp_y_out     = rsp_data.y_out;
   assign rsp_magnitude = rsp_data.magnitude;
   assign rsp_angle     = rsp_data.angle;
   assign rsp_is_polar  = rsp_data.is_polar;

endmodule

// ===== rtl/core/rpc_prep.sv =====
module rpc_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic                                  kind,
   input  logic signed [rpc_pkg::FIRST_WIDTH-1:0]  first_operand,
   input  logic signed [rpc_pkg::SECOND_WIDTH-1:0] second_operand,
   output logic                                  out_valid,
   output rpc_pkg::cordic_type                   out_data
);
   import rpc_pkg::*;

   logic signed [CW2-1:0] a_ext, b_ext, xo, yo, mo;
   logic signed [ZW-1:0]  ao, zq;
   logic signed [XW-1:0]  xs, ys, ms;
   cordic_type            data_in, data_ff;
   logic                  valid_in, valid_ff;

   // Operand clamping, angle wrap and quadrant pre-rotation
   always_comb begin
      a_ext = CW2'(first_operand);
      b_ext = CW2'(second_operand);

      xo = (a_ext > CW2'(CMAX_L)) ? CW2'(CMAX_L) :
           (a_ext < CW2'(CMIN_L)) ? CW2'(CMIN_L) : a_ext;
      yo = (b_ext > CW2'(CMAX_L)) ? CW2'(CMAX_L) :
           (b_ext < CW2'(CMIN_L)) ? CW2'(CMIN_L) : b_ext;
      mo = (a_ext < 0) ? '0 : (a_ext > CW2'(MMAX_L)) ? CW2'(MMAX_L) : a_ext;

      ao = ZW'(b_ext);
      if (ao > HALF_TURN) ao = ao - ZW'(FULL_TURN);
      if (ao < -HALF_TURN) ao = ao + ZW'(FULL_TURN);
      zq = ao <<< Z_SHIFT;

      xs = XW'(xo) <<< GUARD_BITS;
      ys = XW'(yo) <<< GUARD_BITS;
      ms = XW'(mo) <<< GUARD_BITS;

      data_in          = '0;
      data_in.polar    = kind;
      data_in.zero_vec = (xo == 0) && (yo == 0);
      data_in.neg_axis = (yo == 0) && (xo < 0);

      if (kind == KIND_RECT) begin
         data_in.x_echo = COORD_WIDTH'(xo);
         data_in.y_echo = COORD_WIDTH'(yo);
         if (xo < 0) begin
            if (yo >= 0) begin
               data_in.x = ys;
               data_in.y = -xs;
               data_in.z = DEG90;
            end else begin
               data_in.x = -ys;
               data_in.y = xs;
               data_in.z = -DEG90;
            end
         end else begin
            data_in.x = xs;
            data_in.y = ys;
            data_in.z = '0;
         end
      end else begin
         data_in.mag_echo = COORD_WIDTH'(mo);
         data_in.ang_echo = ANGLE_WIDTH'(ao);
         if (zq > DEG90) begin
            data_in.x = '0;
            data_in.y = ms;
            data_in.z = zq - DEG90;
         end else if (zq < -DEG90) begin
            data_in.x = '0;
            data_in.y = -ms;
            data_in.z = zq + DEG90;
         end else begin
            data_in.x = ms;
            data_in.y = '0;
            data_in.z = zq;
         end
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/rpc_iter.sv =====
module rpc_iter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [rpc_pkg::IDX_WIDTH-1:0]   idx,
   input  logic                            in_valid,
   input  rpc_pkg::cordic_type             in_data,
   output logic                            out_valid,
   output rpc_pkg::cordic_type             out_data
);
   import rpc_pkg::*;

   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] step;
   logic                 ccw;
   cordic_type           data_in, data_ff;
   logic                 valid_in, valid_ff;

   // One micro-rotation: vectoring drives y to zero, rotation drives z to zero
   always_comb begin
      dx   = in_data.y >>> idx;
      dy   = in_data.x >>> idx;
      step = atan_entry(idx);
      ccw  = in_data.polar ? ~in_data.z[ZW-1] : in_data.y[XW-1];

      data_in = in_data;
      if (ccw) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - step;
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + step;
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/rpc_post.sv =====
module rpc_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rpc_pkg::cordic_type   in_data,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rpc_pkg::rsp_type      rsp_data
);
   import rpc_pkg::*;

   logic signed [ZW-1:0] zr;
   logic signed [PW-1:0] rx, ry;
   prod_type             prod_in, prod_ff;
   rsp_type              res_in, res_ff, skid_in, skid_ff;
   logic                 prod_valid_in, prod_valid_ff;
   logic                 res_valid_in, res_valid_ff;
   logic                 skid_valid_in, skid_valid_ff;

   // The whole pipeline moves unless the skid holds a result
   assign advance = ~skid_valid_ff;

   // Gain multiply and angle rounding
   always_comb begin
      zr = (in_data.z + ZW'(Z_ROUND)) >>> Z_SHIFT;

      prod_in            = '0;
      prod_in.polar      = in_data.polar;
      prod_in.zero_vec   = in_data.zero_vec;
      prod_in.neg_axis   = in_data.neg_axis;
      prod_in.px         = in_data.x * GAIN_K;
      prod_in.py         = in_data.y * GAIN_K;
      prod_in.ang_cordic = (zr > HALF_TURN)  ? ANGLE_WIDTH'(HALF_TURN) :
                           (zr < -HALF_TURN) ? ANGLE_WIDTH'(-HALF_TURN) :
                                               ANGLE_WIDTH'(zr);
      prod_in.x_echo     = in_data.x_echo;
      prod_in.y_echo     = in_data.y_echo;
      prod_in.mag_echo   = in_data.mag_echo;
      prod_in.ang_echo   = in_data.ang_echo;
   end

   // Rounding shift, saturation and result selection
   always_comb begin
      rx = (prod_ff.px + ROUND_BIAS) >>> DSHIFT;
      ry = (prod_ff.py + ROUND_BIAS) >>> DSHIFT;

      res_in          = '0;
      res_in.is_polar = prod_ff.polar;
      if (prod_ff.polar == KIND_POLAR) begin
         res_in.x_out = (rx > PW'(CMAX_L)) ? COORD_WIDTH'(CMAX_L) :
                        (rx < PW'(CMIN_L)) ? COORD_WIDTH'(CMIN_L) : COORD_WIDTH'(rx);
         res_in.y_out = (ry > PW'(CMAX_L)) ? COORD_WIDTH'(CMAX_L) :
                        (ry < PW'(CMIN_L)) ? COORD_WIDTH'(CMIN_L) : COORD_WIDTH'(ry);
         res_in.magnitude = prod_ff.mag_echo;
         res_in.angle     = prod_ff.ang_echo;
      end else begin
         res_in.x_out = prod_ff.x_echo;
         res_in.y_out = prod_ff.y_echo;
         if (prod_ff.zero_vec) begin
            res_in.magnitude = '0;
            res_in.angle     = '0;
         end else begin
            res_in.magnitude = (rx < 0) ? '0 :
                               (rx > PW'(MMAX_L)) ? COORD_WIDTH'(MMAX_L) : COORD_WIDTH'(rx);
            res_in.angle     = prod_ff.neg_axis ? ANGLE_WIDTH'(HALF_TURN) : prod_ff.ang_cordic;
         end
      end
   end

   // Skid: catches the output stage when the consumer stalls
   always_comb begin
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) skid_valid_in = 1'b0;
      end else if (res_valid_ff && !rsp_ready) begin
         skid_valid_in = 1'b1;
         skid_in       = res_ff;
      end
   end

   assign prod_valid_in = advance ? in_valid      : prod_valid_ff;
   assign res_valid_in  = advance ? prod_valid_ff : res_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         res_valid_ff  <= res_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         res_ff  <= res_in;
      end
      skid_ff <= skid_in;
   end

   assign rsp_valid = skid_valid_ff | res_valid_ff;
   assign rsp_data  = skid_valid_ff ? skid_ff : res_ff;

   // A frozen pipeline always has a result waiting at the output
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !advance |-> rsp_valid)
      else $error("pipeline stalled with no pending result");

   // The skid holds its result until taken
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid result changed while stalled");

   // Zero rectangular vector gives zero length and angle
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_polar && rsp_data.x_out == 0 && rsp_data.y_out == 0
      |-> rsp_data.magnitude == 0 && rsp_data.angle == 0)
      else $error("zero vector gave nonzero magnitude or angle");

   // Angle stays within a half turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.angle <= HALF_TURN && rsp_data.angle >= -HALF_TURN)
      else $error("angle out of range");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import rpc_pkg::*;

   // CORDIC constants for the predictor, angle in 2^-16 degree units
   localparam int     N_STEPS     = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
   localparam longint GUARD_MUL   = 16;
   localparam longint GAIN        = 10188014;
   localparam int     GAIN_BITS   = 28;
   localparam longint QUARTER     = 5898240;
   localparam longint HALF_Q7     = 23040;
   localparam longint FULL_Q7     = 46080;
   localparam longint COORD_HI    = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam longint COORD_LO    = -(64'sd1 <<< (COORD_WIDTH - 1));
   localparam longint MAG_HI      = (64'sd1 <<< COORD_WIDTH) - 64'sd1;
   localparam int     LATENCY     = CORDIC_ITERATIONS + 3;
   localparam int     STALL_LIMIT = 2000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_kind;
   logic signed [FIRST_WIDTH-1:0] req_first_operand;
   logic signed [SECOND_WIDTH-1:0] req_second_operand;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [COORD_WIDTH-1:0] rsp_x_out;
   logic signed [COORD_WIDTH-1:0] rsp_y_out;
   logic [COORD_WIDTH-1:0]        rsp_magnitude;
   logic signed [ANGLE_WIDTH-1:0] rsp_angle;
   logic                          rsp_is_polar;

   rsp_type pending_results[$];
   int      mismatches;
   int      quiet_cycles;
   bit      idle_on;

   rect_polar_converter_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_x_out          (rsp_x_out),
      .rsp_y_out          (rsp_y_out),
      .rsp_magnitude      (rsp_magnitude),
      .rsp_angle          (rsp_angle),
      .rsp_is_polar       (rsp_is_polar)
   );

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // atan(2^-i), entry 0 is 45 degrees
   function automatic longint atan_step(input int idx);
      case (idx)
         0:  return 2949120;
         1:  return 1740967;
         2:  return 919879;
         3:  return 466945;
         4:  return 234379;
         5:  return 117304;
         6:  return 58666;
         7:  return 29335;
         8:  return 14668;
         9:  return 7334;
         10: return 3667;
         11: return 1833;
         12: return 917;
         13: return 458;
         14: return 229;
         15: return 115;
         16: return 57;
         17: return 29;
         18: return 14;
         19: return 7;
         20: return 4;
         21: return 2;
         22: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Remove the CORDIC gain and the guard bits, rounding half up
   function automatic longint remove_gain(input longint v);
      return (v * GAIN + (64'sd1 <<< (GAIN_BITS - 1))) >>> GAIN_BITS;
   endfunction

   // Expected result of one conversion request
   function automatic rsp_type convert_vector(input logic kind,
                                              input logic signed [FIRST_WIDTH-1:0] opa,
                                              input logic signed [SECOND_WIDTH-1:0] opb);
      longint  a, b, xo, yo, mo, ao, xr, yr, zr, tmp, dx, dy;
      rsp_type res;
      a  = opa;
      b  = opb;
      zr = 0;
      if (kind == KIND_RECT) begin
         xo = clamp_to(a, COORD_LO, COORD_HI);
         yo = clamp_to(b, COORD_LO, COORD_HI);
         if (xo == 0 && yo == 0) begin
            mo = 0;
            ao = 0;
         end else begin
            xr = xo * GUARD_MUL;
            yr = yo * GUARD_MUL;
            // left half plane: pre-rotate by 90 degrees into the right half
            if (xo < 0) begin
               if (yo >= 0) begin
                  tmp = xr; xr = yr; yr = -tmp; zr = QUARTER;
               end else begin
                  tmp = xr; xr = -yr; yr = tmp; zr = -QUARTER;
               end
            end
            // vectoring: drive y to zero
            for (int i = 0; i < N_STEPS; i++) begin
               dx = yr >>> i;
               dy = xr >>> i;
               if (yr >= 0) begin
                  xr = xr + dx; yr = yr - dy; zr = zr + atan_step(i);
               end else begin
                  xr = xr - dx; yr = yr + dy; zr = zr - atan_step(i);
               end
            end
            mo = clamp_to(remove_gain(xr), 0, MAG_HI);
            ao = clamp_to((zr + 256) >>> 9, -HALF_Q7, HALF_Q7);
            if (yo == 0 && xo < 0) ao = HALF_Q7;
         end
      end else begin
         mo = clamp_to(a, 0, MAG_HI);
         ao = b;
         if (ao > HALF_Q7) ao = ao - FULL_Q7;
         if (ao < -HALF_Q7) ao = ao + FULL_Q7;
         zr = ao * 512;
         if (zr > QUARTER) begin
            xr = 0; yr = mo * GUARD_MUL; zr = zr - QUARTER;
         end else if (zr < -QUARTER) begin
            xr = 0; yr = -mo * GUARD_MUL; zr = zr + QUARTER;
         end else begin
            xr = mo * GUARD_MUL; yr = 0;
         end
         // rotation: drive the residual angle to zero
         for (int i = 0; i < N_STEPS; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0) begin
               xr = xr - dx; yr = yr + dy; zr = zr - atan_step(i);
            end else begin
               xr = xr + dx; yr = yr - dy; zr = zr + atan_step(i);
            end
         end
         xo = clamp_to(remove_gain(xr), COORD_LO, COORD_HI);
         yo = clamp_to(remove_gain(yr), COORD_LO, COORD_HI);
      end
      res.x_out     = xo[COORD_WIDTH-1:0];
      res.y_out     = yo[COORD_WIDTH-1:0];
      res.magnitude = mo[COORD_WIDTH-1:0];
      res.angle     = ao[ANGLE_WIDTH-1:0];
      res.is_polar  = kind;
      return res;
   endfunction

   // Send one request; called and returns at a falling edge
   task automatic send_req(input logic kind,
                           input logic signed [FIRST_WIDTH-1:0] opa,
                           input logic signed [SECOND_WIDTH-1:0] opb);
      if (idle_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_first_operand  <= opa;
      req_second_operand <= opb;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(convert_vector(kind, opa, opb));
      @(negedge clock);
   endtask

   // Rectangular edge cases: zero vector, axes, extremes, out-of-range inputs
   task automatic test_rect_directed();
      send_req(KIND_RECT, 0, 0);
      send_req(KIND_RECT, 256, 0);
      send_req(KIND_RECT, -256, 0);
      send_req(KIND_RECT, 0, 256);
      send_req(KIND_RECT, 0, -256);
      send_req(KIND_RECT, 32767, 32767);
      send_req(KIND_RECT, -32768, -32768);
      send_req(KIND_RECT, -32768, 0);
      send_req(KIND_RECT, -32768, 32767);
      send_req(KIND_RECT, 65535, -1);
      send_req(KIND_RECT, -65536, 1);
      send_req(KIND_RECT, -1, 0);
      send_req(KIND_RECT, -1, -1);
   endtask

   // Polar edge cases: magnitude limits, negative magnitude, angle wrap, saturation
   task automatic test_polar_directed();
      send_req(KIND_POLAR, 0, 0);
      send_req(KIND_POLAR, 46341, 0);
      send_req(KIND_POLAR, 65535, 5760);
      send_req(KIND_POLAR, -1, 11520);
      send_req(KIND_POLAR, -65536, -11520);
      send_req(KIND_POLAR, 256, 23040);
      send_req(KIND_POLAR, 256, -23040);
      send_req(KIND_POLAR, 256, 23041);
      send_req(KIND_POLAR, 256, -23041);
      send_req(KIND_POLAR, 46341, 32767);
      send_req(KIND_POLAR, 46341, -32768);
      send_req(KIND_POLAR, 32767, -17280);
   endtask

   // Mostly well-formed requests of both kinds, plus small and raw random ones
   task automatic test_random_mix(input int count);
      int                           sel;
      logic signed [COORD_WIDTH-1:0] xv, yv;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         xv  = COORD_WIDTH'($urandom);
         yv  = COORD_WIDTH'($urandom);
         if (sel < 40) begin
            send_req(KIND_RECT, FIRST_WIDTH'(xv), yv);
         end else if (sel < 80) begin
            send_req(KIND_POLAR, FIRST_WIDTH'($urandom_range(46341)),
                     SECOND_WIDTH'($signed($urandom_range(46080)) - 23040));
         end else if (sel < 90) begin
            // near the origin and on the axes
            if ($urandom_range(1))
               send_req(KIND_RECT, FIRST_WIDTH'($signed($urandom_range(8)) - 4),
                        SECOND_WIDTH'($signed($urandom_range(8)) - 4));
            else
               send_req(KIND_RECT, FIRST_WIDTH'(xv), 0);
         end else begin
            send_req(1'($urandom_range(1)), FIRST_WIDTH'($urandom),
                     SECOND_WIDTH'($urandom));
         end
      end
   endtask

   // A long stretch with both sides always ready
   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      test_random_mix(count);
      idle_on = 1'b1;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Result side backpressure
   always @(negedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(99) >= 6) : 1'b1;
   end

   // Compare each result with the oldest expected one
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, x_out %0d y_out %0d", $time, rsp_x_out,
                     rsp_y_out);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("x_out", want.x_out, rsp_x_out);
            check_field("y_out", want.y_out, rsp_y_out);
            check_field("magnitude", want.magnitude, rsp_magnitude);
            check_field("angle", want.angle, rsp_angle);
            check_field("is_polar", want.is_polar, rsp_is_polar);
         end
      end
   end

   // Watchdog on cycles with no handshake
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      mismatches         = 0;
      idle_on            = 1'b1;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_kind           = KIND_RECT;
      req_first_operand  = '0;
      req_second_operand = '0;
      rsp_ready          = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_rect_directed();
      test_polar_directed();
      test_random_mix(1650);
      test_back_to_back(300);
      req_valid <= 1'b0;

      // drain the pipeline
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rpc_pkg.sv
rtl/core/rpc_prep.sv
rtl/core/rpc_iter.sv
rtl/core/rpc_post.sv
rtl/core/rect_polar_converter_top.sv
tb/tb_top.sv
